// File: src/cms_pkg.sv
package cms_pkg;

   localparam int COMMAND_W = 2;
   localparam int VALUE_W   = 32;
   localparam int INDEX_W   = 6;
   localparam int COUNT_W   = 7;
   localparam int STATUS_W  = 2;

   localparam logic [COMMAND_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;

endpackage

// File: src/cms_req_if.sv
interface cms_req_if import cms_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [COMMAND_W-1:0] command;
   value_type            item_value;
   logic [INDEX_W-1:0]   read_index;

   modport source (output valid, command, item_value, read_index, input ready);
   modport sink   (input valid, command, item_value, read_index, output ready);
endinterface

// File: src/cms_rsp_if.sv
interface cms_rsp_if import cms_pkg::*;;
   logic                valid;
   logic                ready;
   value_type           read_data;
   logic [COUNT_W-1:0]  entry_count;
   logic [COUNT_W-1:0]  removed_count;
   logic [STATUS_W-1:0] status;

   modport source (output valid, read_data, entry_count, removed_count, status, input ready);
   modport sink   (input valid, read_data, entry_count, removed_count, status, output ready);
endinterface

// File: src/compacting_multiset_store.sv
// Ordered multiset of signed 32-bit entries with one result per command. An append
// is answered from the idle state, a read goes through the registered RAM read and
// S_READ, and a remove-all walks the occupied entries through the single-port-read
// RAM one per cycle with one shared comparator, compacting in place, then answers
// from S_DONE.
// The block takes no new command while one is in progress or its result is still
// waiting and cannot move out in the same cycle. Entry and removed counts are
// reported modulo 128; only entries below the count are ever read.
module compacting_multiset_store import cms_pkg::*; #(
   parameter int STORE_DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   cms_req_if.sink   req_chan,
   cms_rsp_if.source rsp_chan
);

   localparam int AW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW   = $clog2(STORE_DEPTH + 1);
   localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic [CW-1:0] wr_ff, wr_in;
   logic [CW-1:0] removed_ff, removed_in;
   logic          pend_ff, pend_in;
   value_type     value_ff, value_in;

   logic                rsp_valid_ff, rsp_valid_in;
   value_type           rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [COUNT_W-1:0]  rsp_removed_ff, rsp_removed_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   value_type     ram_wr_data, ram_rd_data;

   logic out_free, req_transfer, is_full, idx_out;

   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign req_transfer = req_chan.valid && req_chan.ready;
   assign is_full      = (fill_ff == CW'(STORE_DEPTH));
   assign idx_out      = CMPW'(req_chan.read_index) >= CMPW'(fill_ff);

   cms_entry_ram #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      rd_in          = rd_ff;
      wr_in          = wr_ff;
      removed_in     = removed_ff;
      pend_in        = 1'b0;
      value_in       = value_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in    = rsp_data_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = fill_ff[AW-1:0];
      ram_wr_data    = req_chan.item_value;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = AW'(req_chan.read_index);

      case (state_ff)
         S_IDLE: begin
            if (req_transfer) begin
               rsp_data_in    = '0;
               rsp_removed_in = '0;
               rsp_status_in  = ST_OK;
               rsp_count_in   = COUNT_W'(fill_ff);
               case (req_chan.command)
                  CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ram_wr_en    = 1'b1;
                        fill_in      = fill_ff + CW'(1);
                        rsp_count_in = COUNT_W'(fill_ff + CW'(1));
                     end
                  end
                  CMD_REMOVE: begin
                     value_in   = req_chan.item_value;
                     rd_in      = '0;
                     wr_in      = '0;
                     removed_in = '0;
                     state_in   = S_SCAN;
                  end
                  CMD_READ: begin
                     if (idx_out) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        ram_rd_en = 1'b1;
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ram_rd_data;
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            // issue the next read while the previous entry is compared
            ram_rd_addr = rd_ff[AW-1:0];
            if (rd_ff < fill_ff) begin
               ram_rd_en = 1'b1;
               rd_in     = rd_ff + CW'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               if (ram_rd_data != value_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = wr_ff[AW-1:0];
                  ram_wr_data = ram_rd_data;
                  wr_in       = wr_ff + CW'(1);
               end else begin
                  removed_in = removed_ff + CW'(1);
               end
            end else if (rd_ff >= fill_ff) begin
               fill_in  = wr_ff;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = '0;
               rsp_count_in   = COUNT_W'(fill_ff);
               rsp_removed_in = COUNT_W'(removed_ff);
               rsp_status_in  = ST_OK;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff          <= rd_in;
      wr_ff          <= wr_in;
      removed_ff     <= removed_in;
      value_ff       <= value_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.read_data     = rsp_data_ff;
   assign rsp_chan.entry_count   = rsp_count_ff;
   assign rsp_chan.removed_count = rsp_removed_ff;
   assign rsp_chan.status        = rsp_status_ff;

endmodule

// File: src/cms_entry_ram.sv
module cms_entry_ram import cms_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  value_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output value_type     rd_data
);

   value_type mem [DEPTH];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sim/compacting_multiset_store_checker.sv
`timescale 1ns / 100ps

module compacting_multiset_store_checker import cms_pkg::*; #(
   parameter int STORE_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [COMMAND_W-1:0] req_command,
   input  value_type            req_item_value,
   input  logic [INDEX_W-1:0]   req_read_index,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  value_type            rsp_read_data,
   input  logic [COUNT_W-1:0]   rsp_entry_count,
   input  logic [COUNT_W-1:0]   rsp_removed_count,
   input  logic [STATUS_W-1:0]  rsp_status,
   output int unsigned          mismatch_count,
   output int unsigned          awaiting_count
);

   typedef struct packed {
      value_type           read_data;
      logic [COUNT_W-1:0]  entry_count;
      logic [COUNT_W-1:0]  removed_count;
      logic [STATUS_W-1:0] status;
   } store_result_type;

   value_type        entries [STORE_DEPTH];
   int unsigned      held;
   store_result_type awaited_results [$];

   // applies one command to the shadow store and returns the result it yields
   function automatic store_result_type apply_command(input logic [COMMAND_W-1:0] cmd,
                                                      input value_type val,
                                                      input logic [INDEX_W-1:0] idx);
      store_result_type res;
      int unsigned      kept;
      int unsigned      removed;
      int unsigned      pos;
      res = '0;
      case (cmd)
         CMD_APPEND: begin
            if (held >= STORE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               entries[held] = val;
               held++;
            end
         end
         CMD_REMOVE: begin
            kept = 0;
            removed = 0;
            // compact in place, survivors keep their order
            for (pos = 0; pos < held; pos++) begin
               if (entries[pos] != val) begin
                  entries[kept] = entries[pos];
                  kept++;
               end else begin
                  removed++;
               end
            end
            held = kept;
            res.removed_count = COUNT_W'(removed);
         end
         CMD_READ: begin
            if (idx >= held) begin
               res.status = ST_RANGE;
            end else begin
               res.read_data = entries[idx];
            end
         end
         default: begin
         end
      endcase
      res.entry_count = COUNT_W'(held);
      return res;
   endfunction

   always @(posedge clock) begin
      store_result_type want;
      if (reset) begin
         held = 0;
         awaited_results.delete();
      end else begin
         // the result side first: a result never belongs to a command taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result data %0d count %0d removed %0d status %0d",
                           $realtime, rsp_read_data, rsp_entry_count, rsp_removed_count,
                           rsp_status);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_read_data !== want.read_data || rsp_entry_count !== want.entry_count ||
                   rsp_removed_count !== want.removed_count || rsp_status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("%0t: expected data %0d count %0d removed %0d status %0d, ",
                            $realtime, want.read_data, want.entry_count, want.removed_count,
                            want.status);
                     $display("got data %0d count %0d removed %0d status %0d",
                              rsp_read_data, rsp_entry_count, rsp_removed_count, rsp_status);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(apply_command(req_command, req_item_value,
                                                    req_read_index));
      end
      awaiting_count = awaited_results.size();
   end

endmodule

// File: sim/compacting_multiset_store_tb.sv
`timescale 1ns / 100ps

module compacting_multiset_store_tb;
   import cms_pkg::*;

   localparam int STORE_DEPTH  = 64;
   localparam int ITEM_TARGET  = 1050;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 200;

   localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned awaiting_count;
   int unsigned commands_sent;
   int unsigned results_taken;
   int unsigned cycle_count;
   int          burst_left;

   cms_req_if req_bus ();
   cms_rsp_if rsp_bus ();

   compacting_multiset_store #(.STORE_DEPTH(STORE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   compacting_multiset_store_checker #(.STORE_DEPTH(STORE_DEPTH)) store_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_command       (req_bus.command),
      .req_item_value    (req_bus.item_value),
      .req_read_index    (req_bus.read_index),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_read_data     (rsp_bus.read_data),
      .rsp_entry_count   (rsp_bus.entry_count),
      .rsp_removed_count (rsp_bus.removed_count),
      .rsp_status        (rsp_bus.status),
      .mismatch_count    (mismatch_count),
      .awaiting_count    (awaiting_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         results_taken++;
   end

   // receiver: stretches of steady, light or heavy stalling, plus one long hold-off
   initial begin
      int stretch;
      int mode;
      bit held_off;
      held_off = 1'b0;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         stretch = $urandom_range(20, 80);
         mode = $urandom_range(0, 2);
         repeat (stretch) begin
            @(negedge clock);
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 1) != 0);
            endcase
         end
         if (!held_off && results_taken >= HOLD_AFTER) begin
            held_off = 1'b1;
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
      end
   end

   // mostly a small pool so that removals hit several entries at once
   function automatic value_type pick_value();
      if ($urandom_range(0, 3) == 0)
         return value_type'($urandom);
      case ($urandom_range(0, 7))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return 0;
         3:       return -1;
         4:       return 1;
         5:       return 5;
         6:       return -5;
         default: return 100;
      endcase
   endfunction

   task automatic send_item(input logic [COMMAND_W-1:0] cmd, input value_type val,
                            input logic [INDEX_W-1:0] idx);
      int gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 30);
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.item_value <= val;
      req_bus.read_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
      commands_sent++;
   endtask

   function automatic logic [INDEX_W-1:0] pick_index();
      if ($urandom_range(0, 1) == 0)
         return INDEX_W'($urandom_range(0, 15));
      return INDEX_W'($urandom_range(0, 63));
   endfunction

   initial begin
      int appends;
      int target;
      int roll;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_APPEND;
      req_bus.item_value = '0;
      req_bus.read_index = '0;
      commands_sent = 0;
      results_taken = 0;
      burst_left = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, no-match removal, empty store, unused code
      send_item(CMD_APPEND, 32'sh7fffffff, 0);
      send_item(CMD_APPEND, 32'sh80000000, 0);
      send_item(CMD_APPEND, 0, 0);
      send_item(CMD_APPEND, -1, 0);
      send_item(CMD_APPEND, 1, 0);
      send_item(CMD_READ, 0, 0);
      send_item(CMD_READ, 0, 1);
      send_item(CMD_READ, 0, 4);
      send_item(CMD_READ, 0, 5);
      send_item(CMD_READ, -1, 63);
      send_item(CMD_REMOVE, 12345, 0);
      send_item(CMD_APPEND, 32'sh7fffffff, 0);
      send_item(CMD_REMOVE, 32'sh7fffffff, 0);
      send_item(CMD_READ, 0, 0);
      send_item(CMD_UNUSED, value_type'($urandom), pick_index());
      send_item(CMD_REMOVE, 32'sh80000000, 0);
      send_item(CMD_REMOVE, 0, 0);
      send_item(CMD_REMOVE, -1, 0);
      send_item(CMD_REMOVE, 1, 0);
      send_item(CMD_REMOVE, -1, 0);
      send_item(CMD_READ, 0, 0);

      while (commands_sent < ITEM_TARGET) begin
         // fill past the depth so appends to a full store show up
         appends = 0;
         target = $urandom_range(50, 80);
         while (appends < target && commands_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 19);
            if (roll < 17) begin
               send_item(CMD_APPEND, pick_value(), pick_index());
               appends++;
            end else if (roll < 19) begin
               send_item(CMD_READ, pick_value(), pick_index());
            end else begin
               send_item(CMD_UNUSED, value_type'($urandom), pick_index());
            end
         end
         repeat ($urandom_range(20, 60)) begin
            if (commands_sent >= ITEM_TARGET)
               break;
            roll = $urandom_range(0, 19);
            if (roll < 7)
               send_item(CMD_APPEND, pick_value(), pick_index());
            else if (roll < 12)
               send_item(CMD_REMOVE, pick_value(), pick_index());
            else if (roll < 19)
               send_item(CMD_READ, pick_value(), pick_index());
            else
               send_item(CMD_UNUSED, value_type'($urandom), pick_index());
         end
         repeat ($urandom_range(3, 10)) begin
            if (commands_sent < ITEM_TARGET)
               send_item(CMD_REMOVE, pick_value(), pick_index());
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaiting_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaiting_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
